### rtl/stereo_chorus_assert.svh
// Assertion macros used by the stereo chorus top level.
`ifndef STEREO_CHORUS_ASSERT_SVH
`define STEREO_CHORUS_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SCH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SCH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sch_pkg.sv
// Package for the stereo chorus: types, constants and the quarter-wave sine polynomial.
`timescale 1ns / 1ps
`default_nettype none
package sch_pkg;

    localparam int LINE_DEPTH_DEF   = 2048;
    localparam int SINE_ENTRIES_DEF = 256;

    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 16;
    localparam int PHASE_W    = 32;
    localparam int DELAY_W    = 19;
    localparam int FRAC_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Serial multiplier: signed multiplicand, unsigned multiplier.
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 19;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MUL_C_W = $clog2(MUL_B_W + 1);

    localparam logic [GAIN_W-1:0]  MIX_UNITY      = 16'h8000;
    localparam logic [PHASE_W-1:0] QUARTER_PHASE  = 32'h4000_0000;
    localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd71583;
    localparam logic [DELAY_W-1:0] CENTRE_RST     = 19'd98304;
    localparam logic [DELAY_W-1:0] DEPTH_RST      = 19'd30720;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WET_MIX    = 3'd0,
        REG_PHASE_STEP = 3'd1,
        REG_CENTRE     = 3'd2,
        REG_MOD_DEPTH  = 3'd3,
        REG_STEREO     = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_DLY,
        ST_POS,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_INT,
        ST_MIXS,
        ST_MIX,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic        [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                      busy;
        logic                      done;
        logic signed [MUL_P_W-1:0] prod;
    } mul_rsp_t;

    // Quarter-wave sine in Q15 from position t in Q15 (elaboration only).
    function automatic logic signed [GAIN_W-1:0] quarter_sine(longint t);
        longint t2;
        longint inner;
        longint outer;
        longint s;
        t2    = (t * t) >> 15;
        inner = 21024 - ((2320 * t2) >> 15);
        outer = 51472 - ((inner * t2) >> 15);
        s     = (outer * t) >> 15;
        if (s > 32767) begin
            s = 32767;
        end
        return GAIN_W'(s);
    endfunction

endpackage
`default_nettype wire

### rtl/sch_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sch_mul (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sch_pkg::mul_req_t req,
    output sch_pkg::mul_rsp_t      rsp
);
    logic signed [sch_pkg::MUL_P_W-1:0] a_reg, a_next;
    logic signed [sch_pkg::MUL_P_W-1:0] acc_reg, acc_next;
    logic [sch_pkg::MUL_B_W-1:0]        b_reg, b_next;
    logic [sch_pkg::MUL_C_W-1:0]        cnt_reg, cnt_next;
    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;

    always_comb begin
        a_next    = a_reg;
        acc_next  = acc_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            a_next    = sch_pkg::MUL_P_W'(req.a);
            b_next    = req.b;
            acc_next  = '0;
            cnt_next  = sch_pkg::MUL_C_W'(sch_pkg::MUL_B_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = a_reg <<< 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == sch_pkg::MUL_C_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;
endmodule
`default_nettype wire

### rtl/sch_line.sv
// One delay line: single-port-write, registered-read sample memory.
`timescale 1ns / 1ps
`default_nettype none
module sch_line #(
    parameter int DEPTH = sch_pkg::LINE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                          aclk,
    input  wire logic                          we,
    input  wire logic [AW-1:0]                 waddr,
    input  wire logic [sch_pkg::SAMPLE_W-1:0]  wdata,
    input  wire logic [AW-1:0]                 raddr,
    output logic      [sch_pkg::SAMPLE_W-1:0]  rdata
);
    logic [sch_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic [sch_pkg::SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

### rtl/stereo_chorus.sv
// Stereo chorus top level: control sequencer, delay lines and serial multiplier.
`timescale 1ns / 1ps
`default_nettype none
// Stereo chorus. Each accepted request is one stereo sample pair; one result pair comes
// back per request. After reset the two delay lines are cleared through all LINE_DEPTH
// entries (2048 by default) before the first request is taken; configuration writes
// are taken at any time but belong in idle periods. One pair is worked at a time. The
// cost is set by the bit-serial multiplier: each of three products per channel runs
// through 19 shift-add steps and a done step, which with the write, address and read
// steps makes up the work on a pair; mono works the left channel only. When wet_mix is
// zero the input pair is passed to the output register as is (bypass, state frozen). A
// finished result waits in the output register while the next request is accepted.
module stereo_chorus #(
    parameter int LINE_DEPTH   = sch_pkg::LINE_DEPTH_DEF,
    parameter int SINE_ENTRIES = sch_pkg::SINE_ENTRIES_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [sch_pkg::SAMPLE_W-1:0] s_in_left,
    input  wire logic signed [sch_pkg::SAMPLE_W-1:0] s_in_right,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [sch_pkg::SAMPLE_W-1:0]      m_out_left,
    output logic signed [sch_pkg::SAMPLE_W-1:0]      m_out_right,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sch_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [sch_pkg::CFG_DATA_W-1:0]      cfg_data
);
    `include "stereo_chorus_assert.svh"

    localparam int AW    = $clog2(LINE_DEPTH);
    localparam int POS_W = AW + 10;
    localparam int SIX_W = $clog2(SINE_ENTRIES);
    localparam int SPR_W = sch_pkg::PHASE_W + SIX_W;
    localparam int SW    = sch_pkg::SAMPLE_W;
    localparam int DMIN  = 256;
    localparam int DMAX  = (LINE_DEPTH - 2) * 256;
    localparam int SPAN  = LINE_DEPTH * 256;

    typedef logic signed [sch_pkg::GAIN_W-1:0] sine_tab_t [SINE_ENTRIES];

    function automatic sine_tab_t build_sine();
        sine_tab_t tab;
        longint    q4;
        longint    quad;
        longint    r;
        longint    t;
        logic signed [sch_pkg::GAIN_W-1:0] s;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            q4   = 4 * k;
            quad = q4 / SINE_ENTRIES;
            r    = q4 % SINE_ENTRIES;
            t    = (r << 15) / SINE_ENTRIES;
            if (quad % 2 == 1) begin
                t = 32768 - t;
            end
            s      = sch_pkg::quarter_sine(t);
            tab[k] = (quad >= 2) ? -s : s;
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();

    sch_pkg::state_t state_reg, state_next;

    logic [sch_pkg::GAIN_W-1:0]   wet_mix_reg;
    logic [sch_pkg::PHASE_W-1:0]  phase_step_reg;
    logic [sch_pkg::DELAY_W-1:0]  centre_reg;
    logic [sch_pkg::DELAY_W-1:0]  depth_reg;
    logic                         stereo_reg;

    logic [AW-1:0]                clr_reg, clr_next;
    logic [AW-1:0]                wi_reg, wi_next;
    logic [sch_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic                         ch_reg, ch_next;
    logic                         m_valid_reg, m_valid_next;

    logic signed [SW-1:0]             dry_l_reg, dry_r_reg;
    logic signed [sch_pkg::GAIN_W-1:0] lfo_l_reg, lfo_r_reg;
    logic [POS_W-1:0]                 d_reg, d_next;
    logic [AW-1:0]                    i0_reg, i1_reg;
    logic [sch_pkg::FRAC_W-1:0]       f_reg;
    logic signed [SW-1:0]             x0_reg, wet_reg, wet_next;
    logic signed [SW-1:0]             res_l_reg, res_r_reg, res_next;
    logic signed [SW-1:0]             m_left_reg, m_right_reg;

    logic [sch_pkg::GAIN_W-1:0]       mix_eff;
    logic                             in_fire;
    logic [SPR_W-1:0]                 idx_l_prod, idx_r_prod;
    logic signed [sch_pkg::GAIN_W-1:0] lfo_cur;
    logic signed [SW-1:0]             dry_cur, rd_cur;
    logic signed [sch_pkg::MUL_P_W-1:0] prod_sh15, prod_sh8, prod_mix;
    logic signed [31:0]               d_raw;
    logic [POS_W-1:0]                 pos_sum, pos_w;
    logic [AW-1:0]                    i0_w;
    logic signed [SW+1:0]             mix_sum;

    logic                   line_we;
    logic [AW-1:0]          line_waddr, line_raddr;
    logic [SW-1:0]          wdata_l, wdata_r, rdata_l, rdata_r;

    sch_pkg::mul_req_t mul_req;
    sch_pkg::mul_rsp_t mul_rsp;

    sch_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    sch_line #(.DEPTH(LINE_DEPTH), .AW(AW)) u_line_l (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (wdata_l),
        .raddr (line_raddr),
        .rdata (rdata_l)
    );

    sch_line #(.DEPTH(LINE_DEPTH), .AW(AW)) u_line_r (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (wdata_r),
        .raddr (line_raddr),
        .rdata (rdata_r)
    );

    assign mix_eff   = (wet_mix_reg > sch_pkg::MIX_UNITY) ? sch_pkg::MIX_UNITY : wet_mix_reg;
    assign s_ready   = (state_reg == sch_pkg::ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Table index is the top bits of phase * SINE_ENTRIES.
    assign idx_l_prod = SPR_W'(phase_reg) * SPR_W'(SINE_ENTRIES);
    assign idx_r_prod = SPR_W'(phase_reg + sch_pkg::QUARTER_PHASE) * SPR_W'(SINE_ENTRIES);

    assign lfo_cur = ch_reg ? lfo_r_reg : lfo_l_reg;
    assign dry_cur = ch_reg ? dry_r_reg : dry_l_reg;
    assign rd_cur  = ch_reg ? rdata_r : rdata_l;

    assign prod_sh15 = mul_rsp.prod >>> 15;
    assign prod_sh8  = mul_rsp.prod >>> 8;
    assign prod_mix  = (mul_rsp.prod + sch_pkg::MUL_P_W'(16384)) >>> 15;

    assign d_raw = $signed({13'd0, centre_reg}) + prod_sh15[31:0];

    always_comb begin
        if (d_raw < 32'sd256) begin
            d_next = POS_W'(DMIN);
        end else if (d_raw > 32'(DMAX)) begin
            d_next = POS_W'(DMAX);
        end else begin
            d_next = d_raw[POS_W-1:0];
        end
    end

    // Read position wraps once at most since the delay stays inside the line.
    assign pos_sum = {2'b00, wi_reg, 8'h00} + POS_W'(SPAN) - d_reg;
    assign pos_w   = (pos_sum >= POS_W'(SPAN)) ? pos_sum - POS_W'(SPAN) : pos_sum;
    assign i0_w    = pos_w[AW+7:8];

    assign wet_next = SW'(SW'(x0_reg) + prod_sh8[SW-1:0]);

    assign mix_sum = (SW+2)'(dry_cur) + prod_mix[SW+1:0];
    always_comb begin
        if (mix_sum > (SW+2)'(8388607)) begin
            res_next = SW'(8388607);
        end else if (mix_sum < -(SW+2)'(8388608)) begin
            res_next = -SW'(8388608);
        end else begin
            res_next = mix_sum[SW-1:0];
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        wi_next      = wi_reg;
        phase_next   = phase_reg;
        ch_next      = ch_reg;
        m_valid_next = m_valid_reg;
        line_we      = 1'b0;
        line_waddr   = wi_reg;
        line_raddr   = i0_reg;
        wdata_l      = dry_l_reg;
        wdata_r      = stereo_reg ? dry_r_reg : dry_l_reg;
        mul_req      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            sch_pkg::ST_CLEAR: begin
                line_we    = 1'b1;
                line_waddr = clr_reg;
                wdata_l    = '0;
                wdata_r    = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == AW'(LINE_DEPTH - 1)) begin
                    state_next = sch_pkg::ST_IDLE;
                end
            end
            sch_pkg::ST_IDLE: begin
                if (in_fire) begin
                    ch_next    = 1'b0;
                    state_next = (mix_eff == '0) ? sch_pkg::ST_OUT : sch_pkg::ST_WRITE;
                end
            end
            sch_pkg::ST_WRITE: begin
                line_we     = 1'b1;
                mul_req.start = 1'b1;
                mul_req.a   = sch_pkg::MUL_A_W'(lfo_cur);
                mul_req.b   = depth_reg;
                state_next  = sch_pkg::ST_DLY;
            end
            sch_pkg::ST_DLY: begin
                if (mul_rsp.done) begin
                    state_next = sch_pkg::ST_POS;
                end
            end
            sch_pkg::ST_POS: begin
                state_next = sch_pkg::ST_RD0;
            end
            sch_pkg::ST_RD0: begin
                line_raddr = i0_reg;
                state_next = sch_pkg::ST_RD1;
            end
            sch_pkg::ST_RD1: begin
                line_raddr = i1_reg;
                state_next = sch_pkg::ST_RD2;
            end
            sch_pkg::ST_RD2: begin
                mul_req.start = 1'b1;
                mul_req.a   = sch_pkg::MUL_A_W'(rd_cur) - sch_pkg::MUL_A_W'(x0_reg);
                mul_req.b   = sch_pkg::MUL_B_W'(f_reg);
                state_next  = sch_pkg::ST_INT;
            end
            sch_pkg::ST_INT: begin
                if (mul_rsp.done) begin
                    state_next = sch_pkg::ST_MIXS;
                end
            end
            sch_pkg::ST_MIXS: begin
                mul_req.start = 1'b1;
                mul_req.a   = sch_pkg::MUL_A_W'(wet_reg) - sch_pkg::MUL_A_W'(dry_cur);
                mul_req.b   = sch_pkg::MUL_B_W'(mix_eff);
                state_next  = sch_pkg::ST_MIX;
            end
            sch_pkg::ST_MIX: begin
                if (mul_rsp.done) begin
                    if (!ch_reg && stereo_reg) begin
                        // advance to the right channel
                        ch_next       = 1'b1;
                        mul_req.start = 1'b1;
                        mul_req.a     = sch_pkg::MUL_A_W'(lfo_r_reg);
                        mul_req.b     = depth_reg;
                        state_next    = sch_pkg::ST_DLY;
                    end else begin
                        wi_next    = (wi_reg == AW'(LINE_DEPTH - 1)) ? '0 : wi_reg + 1'b1;
                        phase_next = phase_reg + phase_step_reg;
                        state_next = sch_pkg::ST_OUT;
                    end
                end
            end
            sch_pkg::ST_OUT: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = sch_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sch_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sch_pkg::ST_CLEAR;
            clr_reg        <= '0;
            wi_reg         <= '0;
            phase_reg      <= '0;
            ch_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
            wet_mix_reg    <= '0;
            phase_step_reg <= sch_pkg::PHASE_STEP_RST;
            centre_reg     <= sch_pkg::CENTRE_RST;
            depth_reg      <= sch_pkg::DEPTH_RST;
            stereo_reg     <= 1'b1;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            wi_reg      <= wi_next;
            phase_reg   <= phase_next;
            ch_reg      <= ch_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (sch_pkg::cfg_reg_t'(cfg_addr))
                    sch_pkg::REG_WET_MIX:    wet_mix_reg    <= cfg_data[sch_pkg::GAIN_W-1:0];
                    sch_pkg::REG_PHASE_STEP: phase_step_reg <= cfg_data;
                    sch_pkg::REG_CENTRE:     centre_reg     <= cfg_data[sch_pkg::DELAY_W-1:0];
                    sch_pkg::REG_MOD_DEPTH:  depth_reg      <= cfg_data[sch_pkg::DELAY_W-1:0];
                    sch_pkg::REG_STEREO:     stereo_reg     <= cfg_data[0];
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            dry_l_reg <= s_in_left;
            dry_r_reg <= s_in_right;
            res_l_reg <= s_in_left;
            res_r_reg <= s_in_right;
            lfo_l_reg <= SINE_TAB[idx_l_prod[SPR_W-1:sch_pkg::PHASE_W]];
            lfo_r_reg <= SINE_TAB[idx_r_prod[SPR_W-1:sch_pkg::PHASE_W]];
        end
        if (state_reg == sch_pkg::ST_DLY && mul_rsp.done) begin
            d_reg <= d_next;
        end
        if (state_reg == sch_pkg::ST_POS) begin
            i0_reg <= i0_w;
            i1_reg <= (i0_w == AW'(LINE_DEPTH - 1)) ? '0 : i0_w + 1'b1;
            f_reg  <= pos_w[7:0];
        end
        if (state_reg == sch_pkg::ST_RD1) begin
            x0_reg <= rd_cur;
        end
        if (state_reg == sch_pkg::ST_INT && mul_rsp.done) begin
            wet_reg <= wet_next;
        end
        if (state_reg == sch_pkg::ST_MIX && mul_rsp.done) begin
            if (ch_reg) begin
                res_r_reg <= res_next;
            end else begin
                res_l_reg <= res_next;
            end
        end
        if (state_reg == sch_pkg::ST_OUT && (!m_valid_reg || m_ready)) begin
            m_left_reg  <= res_l_reg;
            m_right_reg <= res_r_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_left  = m_left_reg;
    assign m_out_right = m_right_reg;

    `SCH_ASSERT_NOW(a_no_req_in_clear, state_reg == sch_pkg::ST_CLEAR, !s_ready,
        "request taken during line clear")
    `SCH_ASSERT_NEXT(a_bypass_frozen, in_fire && (mix_eff == '0),
        $stable(wi_reg) && $stable(phase_reg), "bypass request changed state")
    `SCH_ASSERT_NOW(a_mul_idle_start, mul_req.start, !mul_rsp.busy,
        "multiplier restarted while busy")
    `SCH_ASSERT_NOW(a_delay_range, state_reg == sch_pkg::ST_POS,
        (d_reg >= POS_W'(DMIN)) && (d_reg <= POS_W'(DMAX)), "delay outside line")
endmodule
`default_nettype wire
